[rtl/lfo_pkg.sv]
// Shared types, constants and the sine point function of the LFO waveform generator.
package lfo_pkg;

    // Default table sizes handed to the top level parameters.
    localparam int NOISE_ENTRIES_DEF = 1024;
    localparam int SINE_ENTRIES_DEF  = 256;

    // Field and register widths.
    localparam int PHASE_W     = 24;
    localparam int SAMPLE_W    = 16;
    localparam int NOISE_IDX_W = 10;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int PROD_W  = 48;

    // Register map: word index taken from paddr[2].
    localparam logic REG_PHASE_STEP = 1'b0;

    // Input function codes.
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Shape thresholds (0.2, 0.4, 0.6 and 0.8 of full scale).
    localparam logic [SAMPLE_W-1:0] SHAPE_SINE_END  = 16'd13107;
    localparam logic [SAMPLE_W-1:0] SHAPE_RISE_END  = 16'd26214;
    localparam logic [SAMPLE_W-1:0] SHAPE_FALL_END  = 16'd39321;
    localparam logic [SAMPLE_W-1:0] SHAPE_PULSE_END = 16'd52428;

    // Mixing constants: full scale, its square and half the square rounded down.
    localparam logic [SAMPLE_W-1:0] LEVEL_MAX   = 16'hFFFF;
    localparam logic [31:0]         FULL_SQUARE = 32'hFFFE_0001;
    localparam logic [PROD_W-1:0]   ROUND_BIAS  = 48'd2147418112;

    // The remainder after the quotient estimate stays below three times the divisor.
    localparam int REM_W = 34;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADDR,
        ST_READ,
        ST_SQUARE,
        ST_MIX,
        ST_EST,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        WAVE_SINE,
        WAVE_RISE,
        WAVE_FALL,
        WAVE_PULSE,
        WAVE_NOISE
    } wave_t;

    // Sine of a 24-bit phase mapped to 0..65535 as (sin + 1) / 2. The angle is
    // folded into the first quadrant and sin is a floored Q30 Horner series.
    function automatic logic [SAMPLE_W-1:0] sine_level(input logic [PHASE_W-1:0] q);
        longint unsigned quad;
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned lvl;
        quad = longint'(q[23:22]);
        r    = longint'(q[21:0]);
        if (quad[0]) begin
            r = 64'h40_0000 - r;
        end
        x  = (r * 64'd1686629713) >> 22;
        x2 = (x * x) >> 30;
        t  = 64'd1073741824 - x2 / 110;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 72;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 42;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 20;
        t  = 64'd1073741824 - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        if (s > 64'd1073741824) begin
            s = 64'd1073741824;
        end
        if (quad < 2) begin
            lvl = ((64'd1073741824 + s) * 64'd65535 + 64'd1073741824) >> 31;
        end else begin
            lvl = ((64'd1073741824 - s) * 64'd65535 + 64'd1073741824) >> 31;
        end
        return lvl[SAMPLE_W-1:0];
    endfunction

endpackage

[rtl/lfo_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module lfo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/lfo_waveform_generator_core.sv]
// Top level of the LFO waveform generator: phase accumulator, waveform lookup and depth mix.
//
// Each tick transaction (func = 0) reads the waveform at the current 24-bit phase, mixes it
// with the depth as w*d^2 + (1 - d^2) in Q0.16 and returns one level, then advances the
// phase by the phase_step register (APB word 0). The shape input selects sine, rising saw,
// falling saw, pulse or noise at 0.2/0.4/0.6/0.8 of full scale. A write transaction
// (func = 1) stores noise_value at noise_index in the noise RAM, returns nothing and leaves
// the phase alone; an index beyond the table is dropped. Noise entries hold no defined
// value until written, so a noise tick must only land on written entries. A tick passes
// through the accept state, the shared multiplier for the table index, a registered table
// read, the same multiplier again for depth squared and then for the product with 1 - w
// plus the rounding bias, a quotient estimate for the 65535^2 scale, compare and subtract
// steps that correct that estimate (one per correction and a final check), and a hand-off
// of the level to the output register. s_ready is high only while the block is idle. The
// output register lets the next transaction be accepted while a level still waits for
// m_ready; a tick finishing before that level is taken holds until it is.
module lfo_waveform_generator_core
    import lfo_pkg::*;
#(
    parameter int NOISE_ENTRIES = NOISE_ENTRIES_DEF,
    parameter int SINE_ENTRIES  = SINE_ENTRIES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    // Input channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_func,
    input  logic [SAMPLE_W-1:0]    s_depth,
    input  logic [SAMPLE_W-1:0]    s_shape,
    input  logic [NOISE_IDX_W-1:0] s_noise_index,
    input  logic [SAMPLE_W-1:0]    s_noise_value,
    // Result channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [SAMPLE_W-1:0]    m_level
);

    localparam int NOISE_ADDR_W = $clog2(NOISE_ENTRIES);
    localparam int SINE_IDX_W   = $clog2(SINE_ENTRIES);

    // The sine table is built at elaboration, one point per entry phase.
    logic [SAMPLE_W-1:0] sine_rom [SINE_ENTRIES];

    for (genvar gi = 0; gi < SINE_ENTRIES; gi++) begin : g_sine
        localparam logic [PHASE_W-1:0] POINT_PHASE =
            PHASE_W'((64'(gi) << PHASE_W) / SINE_ENTRIES);
        assign sine_rom[gi] = sine_level(POINT_PHASE);
    end

    state_t                  state_reg, state_next;
    wave_t                   wave_reg, wave_next;
    logic [PHASE_W-1:0]      phase_step_reg;
    logic [PHASE_W-1:0]      phase_acc_reg, phase_acc_next;
    logic [SAMPLE_W-1:0]     depth_reg, depth_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [SAMPLE_W-1:0]     wave_val_reg, wave_val_next;
    logic [SAMPLE_W-1:0]     sine_word_reg;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic [SAMPLE_W-1:0]     quo_reg, quo_next;
    logic                    m_valid_reg, m_valid_next;
    logic [SAMPLE_W-1:0]     m_level_reg, m_level_next;

    logic [MUL_A_W-1:0]      mul_a;
    logic [MUL_B_W-1:0]      mul_b;
    logic [MUL_P_W-1:0]      mul_p;
    logic [PROD_W-1:0]       mix_sum;
    logic [SAMPLE_W-1:0]     est_quo;
    logic [REM_W-1:0]        est_rem;
    logic                    div_ge;
    logic                    out_free;
    logic                    s_fire;
    logic                    cfg_write;

    logic                    noise_wr_en;
    logic [NOISE_ADDR_W-1:0] noise_wr_addr;
    logic [NOISE_ADDR_W-1:0] noise_rd_addr;
    logic [SAMPLE_W-1:0]     noise_rd_data;

    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    // Configuration register read back.
    always_comb begin
        unique case (paddr[2])
            REG_PHASE_STEP: prdata = APB_DATA_W'(phase_step_reg);
            default:        prdata = '0;
        endcase
    end

    // Noise table. Writes come straight from an accepted write transaction.
    assign noise_wr_en   = s_fire && (s_func == FUNC_WRITE) &&
                           (32'(s_noise_index) < 32'(NOISE_ENTRIES));
    assign noise_wr_addr = NOISE_ADDR_W'(s_noise_index);
    assign noise_rd_addr = prod_reg[PHASE_W +: NOISE_ADDR_W];

    lfo_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (NOISE_ENTRIES)
    ) u_noise_ram (
        .aclk    (aclk),
        .wr_en   (noise_wr_en),
        .wr_addr (noise_wr_addr),
        .wr_data (s_noise_value),
        .rd_addr (noise_rd_addr),
        .rd_data (noise_rd_data)
    );

    // The single multiplier serves the table index, depth squared and the mix product.
    assign mul_p = mul_a * mul_b;

    always_comb begin
        unique case (state_reg)
            ST_ADDR: begin
                mul_a = MUL_A_W'(phase_acc_reg);
                mul_b = (wave_reg == WAVE_NOISE) ? MUL_B_W'(NOISE_ENTRIES)
                                                 : MUL_B_W'(SINE_ENTRIES);
            end
            ST_SQUARE: begin
                mul_a = MUL_A_W'(depth_reg);
                mul_b = MUL_B_W'(depth_reg);
            end
            ST_MIX: begin
                mul_a = prod_reg[MUL_A_W-1:0];
                mul_b = MUL_B_W'(LEVEL_MAX - wave_val_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // The level is 65535 - round((d^2 * (65535 - w)) / 65535^2); the bias sets the rounding.
    assign mix_sum = mul_p[PROD_W-1:0] + ROUND_BIAS;

    // Since 65535^2 = 2^32 - 2^17 + 1, the top 16 bits of the dividend fall short of the
    // quotient by at most two. The remainder left by that estimate is the low 32 bits plus
    // the estimate times 2^17 - 1, and a few compare and subtract steps finish the job.
    assign est_quo = prod_reg[PROD_W-1 -: SAMPLE_W];
    assign est_rem = REM_W'(prod_reg[31:0]) + (REM_W'(est_quo) << 17) - REM_W'(est_quo);
    assign div_ge  = rem_reg >= REM_W'(FULL_SQUARE);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_func == FUNC_TICK)) begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:   state_next = ST_READ;
            ST_READ:   state_next = ST_SQUARE;
            ST_SQUARE: state_next = ST_MIX;
            ST_MIX:    state_next = ST_EST;
            ST_EST:    state_next = ST_DIV;
            ST_DIV: begin
                if (!div_ge) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs per state.
    always_comb begin
        s_ready        = (state_reg == ST_IDLE);
        wave_next      = wave_reg;
        depth_next     = depth_reg;
        phase_acc_next = phase_acc_reg;
        prod_next      = prod_reg;
        wave_val_next  = wave_val_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_level_next   = m_level_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_func == FUNC_TICK)) begin
                    depth_next = s_depth;
                    if (s_shape < SHAPE_SINE_END) begin
                        wave_next = WAVE_SINE;
                    end else if (s_shape < SHAPE_RISE_END) begin
                        wave_next = WAVE_RISE;
                    end else if (s_shape < SHAPE_FALL_END) begin
                        wave_next = WAVE_FALL;
                    end else if (s_shape < SHAPE_PULSE_END) begin
                        wave_next = WAVE_PULSE;
                    end else begin
                        wave_next = WAVE_NOISE;
                    end
                end
            end
            ST_ADDR: begin
                prod_next = mul_p[PROD_W-1:0];
            end
            ST_READ: begin
                // Table reads land in their output registers at the end of this cycle.
            end
            ST_SQUARE: begin
                prod_next = mul_p[PROD_W-1:0];
                case (wave_reg)
                    WAVE_SINE:  wave_val_next = sine_word_reg;
                    WAVE_RISE:  wave_val_next = phase_acc_reg[PHASE_W-1 -: SAMPLE_W];
                    WAVE_FALL:  wave_val_next = ~phase_acc_reg[PHASE_W-1 -: SAMPLE_W];
                    WAVE_PULSE: wave_val_next = phase_acc_reg[PHASE_W-1] ? '0 : LEVEL_MAX;
                    WAVE_NOISE: wave_val_next = noise_rd_data;
                    default:    wave_val_next = '0;
                endcase
            end
            ST_MIX: begin
                prod_next = mix_sum;
            end
            ST_EST: begin
                rem_next = est_rem;
                quo_next = est_quo;
            end
            ST_DIV: begin
                if (div_ge) begin
                    rem_next = rem_reg - REM_W'(FULL_SQUARE);
                    quo_next = quo_reg + SAMPLE_W'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_level_next   = LEVEL_MAX - quo_reg;
                    phase_acc_next = phase_acc_reg + phase_step_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            phase_step_reg <= '0;
            phase_acc_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_acc_reg <= phase_acc_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_write && (paddr[2] == REG_PHASE_STEP)) begin
                phase_step_reg <= pwdata[PHASE_W-1:0];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        wave_reg      <= wave_next;
        depth_reg     <= depth_next;
        prod_reg      <= prod_next;
        wave_val_reg  <= wave_val_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        m_level_reg   <= m_level_next;
        sine_word_reg <= sine_rom[prod_reg[PHASE_W +: SINE_IDX_W]];
    end

    assign m_valid = m_valid_reg;
    assign m_level = m_level_reg;

endmodule
